FILE: src/key_escape_decoder_line_buffer_core_assert.svh
// Assertion macros shared by the decoder RTL.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef KEY_ESCAPE_DECODER_LINE_BUFFER_CORE_ASSERT_SVH
`define KEY_ESCAPE_DECODER_LINE_BUFFER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/kedlb_pkg.sv
// Shared types, constants and helper functions of the escape decoder.
// No dependencies; imported by every module of the block.
package kedlb_pkg;

    localparam int MAX_LINE_LEN = 20;
    localparam int CNT_W  = $clog2(MAX_LINE_LEN + 1);
    localparam int IDX_W  = (MAX_LINE_LEN > 1) ? $clog2(MAX_LINE_LEN) : 1;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;
    localparam int CMD_W  = 4;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] KEY_BS        = 8'd8;
    localparam logic [7:0] KEY_LF        = 8'd10;
    localparam logic [7:0] KEY_CR        = 8'd13;
    localparam logic [7:0] KEY_ESC       = 8'd27;
    localparam logic [7:0] KEY_BRACKET   = 8'd91;
    localparam logic [7:0] KEY_BACKQUOTE = 8'd96;
    localparam logic [7:0] KEY_TILDE     = 8'd126;
    localparam logic [7:0] KEY_DEL       = 8'd127;
    localparam logic [7:0] KEY_A         = 8'd65;
    localparam logic [7:0] KEY_B         = 8'd66;
    localparam logic [7:0] KEY_C         = 8'd67;
    localparam logic [7:0] KEY_D         = 8'd68;
    localparam logic [7:0] KEY_1         = 8'd49;
    localparam logic [7:0] KEY_2         = 8'd50;
    localparam logic [7:0] KEY_5         = 8'd53;

    typedef enum logic [CMD_W-1:0] {
        OP_NONE       = 4'd0,
        OP_RIGHT      = 4'd1,
        OP_LEFT       = 4'd2,
        OP_UP         = 4'd3,
        OP_DOWN       = 4'd4,
        OP_MOVE_LEFT  = 4'd5,
        OP_ENTER      = 4'd6,
        OP_MOVE_RIGHT = 4'd7,
        OP_TYPED      = 4'd8,
        OP_QUIT       = 4'd9
    } t_command;

    typedef enum logic [1:0] {
        PS_IDLE,
        PS_ESC,
        PS_CSI,
        PS_TILDE
    } t_parse_state;

    typedef enum logic {
        CS_RUN,
        CS_DRAIN
    } t_ctrl_state;

    // controller -> datapath
    typedef struct packed {
        logic     load_res;
        t_command res_cmd;
        logic     append;
        logic     del_ch;
        logic     clear;
        logic     drain_start;
        logic     drain_step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic drain_last;
    } t_dp_status;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122) ||
               (b >= 8'd48 && b <= 8'd57) || (b == 8'd32);
    endfunction

    function automatic logic is_erase(input logic [7:0] b);
        return (b == KEY_BS) || (b == KEY_DEL);
    endfunction

    function automatic logic is_newline(input logic [7:0] b);
        return (b == KEY_CR) || (b == KEY_LF);
    endfunction

endpackage

FILE: src/kedlb_ctrl.sv
// Controller: escape-sequence parser and line-drain sequencer.
// Depends on kedlb_pkg; drives the datapath through t_dp_cmd.
module kedlb_ctrl
    import kedlb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_clear,
    input  logic [7:0] i_key_byte,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state  r_state, n_state;
    t_parse_state r_parse, n_parse;
    logic         plain;
    logic         enter;
    t_command     code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_RUN;
            r_parse <= PS_IDLE;
        end else begin
            r_state <= n_state;
            r_parse <= n_parse;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_parse    = r_parse;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        plain      = 1'b0;
        enter      = 1'b0;
        code       = OP_NONE;
        case (r_state)
            CS_RUN: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_in_clear) begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.load_res = 1'b1;
                        o_cmd.res_cmd  = OP_NONE;
                    end else if (i_key_byte == KEY_BACKQUOTE) begin
                        o_cmd.load_res = 1'b1;
                        o_cmd.res_cmd  = OP_QUIT;
                    end else begin
                        case (r_parse)
                            PS_IDLE: begin
                                if (i_key_byte == KEY_ESC) n_parse = PS_ESC;
                                else                       plain   = 1'b1;
                            end
                            PS_ESC: begin
                                if (i_key_byte == KEY_BRACKET) begin
                                    n_parse = PS_CSI;
                                end else begin
                                    n_parse = PS_IDLE;
                                    plain   = 1'b1;
                                end
                            end
                            PS_CSI: begin
                                n_parse = PS_IDLE;
                                if (i_key_byte == KEY_A)      code = OP_UP;
                                else if (i_key_byte == KEY_B) code = OP_DOWN;
                                else if (i_key_byte == KEY_C) code = OP_RIGHT;
                                else if (i_key_byte == KEY_D) code = OP_LEFT;
                                else if (i_key_byte == KEY_1) begin
                                    code    = OP_ENTER;
                                    n_parse = PS_TILDE;
                                end else if (i_key_byte == KEY_2) begin
                                    code    = OP_MOVE_LEFT;
                                    n_parse = PS_TILDE;
                                end else if (i_key_byte == KEY_5) begin
                                    code    = OP_MOVE_RIGHT;
                                    n_parse = PS_TILDE;
                                end else begin
                                    plain = 1'b1;
                                end
                            end
                            default: begin
                                n_parse = PS_IDLE;
                                plain   = (i_key_byte != KEY_TILDE);
                            end
                        endcase

                        if (plain) begin
                            o_cmd.append = is_printable(i_key_byte);
                            o_cmd.del_ch = is_erase(i_key_byte);
                            enter        = is_newline(i_key_byte);
                        end

                        if (enter && !i_status.count_zero) begin
                            o_cmd.drain_start = 1'b1;
                            n_state           = CS_DRAIN;
                        end else begin
                            o_cmd.load_res = 1'b1;
                            o_cmd.res_cmd  = enter ? OP_TYPED : code;
                        end
                    end
                end
            end
            CS_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.drain_step = 1'b1;
                    if (i_status.drain_last) n_state = CS_RUN;
                end
            end
            default: begin
                n_state = CS_RUN;
            end
        endcase
    end

endmodule

FILE: src/kedlb_dp.sv
// Datapath: line store, character count, drain index and output register.
// Depends on kedlb_pkg and the assertion macro header.
`include "key_escape_decoder_line_buffer_core_assert.svh"

module kedlb_dp
    import kedlb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [7:0]        i_key_byte,
    input  logic              i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output t_command          o_out_cmd,
    output logic [CHAR_W-1:0] o_out_char,
    output logic [LEN_W-1:0]  o_out_len,
    output logic              o_out_last
);

    logic [CHAR_W-1:0] r_store [MAX_LINE_LEN];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    t_command          r_out_cmd;
    logic [CHAR_W-1:0] r_out_char;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;
    logic              room;
    logic              drain_last;

    assign room       = (r_count < CNT_W'(MAX_LINE_LEN));
    assign drain_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear)                          n_count = '0;
        else if (i_cmd.append && room)            n_count = r_count + CNT_W'(1);
        else if (i_cmd.del_ch && r_count != '0)   n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && room) r_store[r_count[IDX_W-1:0]] <= i_key_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.drain_start)     r_idx <= '0;
            else if (i_cmd.drain_step) r_idx <= r_idx + IDX_W'(1);
            if (i_cmd.load_res || i_cmd.drain_step) r_out_valid <= 1'b1;
            else if (i_out_ready)                   r_out_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_out_cmd  <= i_cmd.res_cmd;
            r_out_char <= '0;
            r_out_len  <= LEN_W'(n_count);
            r_out_last <= 1'b1;
        end else if (i_cmd.drain_step) begin
            r_out_cmd  <= OP_TYPED;
            r_out_char <= r_store[r_idx];
            r_out_len  <= LEN_W'(r_count);
            r_out_last <= drain_last;
        end
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.drain_last = drain_last;
    assign o_out_valid = r_out_valid;
    assign o_out_cmd   = r_out_cmd;
    assign o_out_char  = r_out_char;
    assign o_out_len   = r_out_len;
    assign o_out_last  = r_out_last;

    `ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !i_cmd.load_res && !i_cmd.drain_step, "result overwritten while stalled")
    `ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_LINE_LEN), "line count above limit")
    `ASSERT_IMP(a_drain_in_line, i_clk, i_rst_n, i_cmd.drain_step, CNT_W'(r_idx) < r_count, "drain index past line end")
    `ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, r_count == '0, "clear left characters in line")

endmodule

FILE: src/key_escape_decoder_line_buffer_core.sv
// Results are registered; a CR/LF run passes the drain state before its first typed result.
// Throughput: one byte per cycle while the result register is free; on a CR/LF a line
// of N chars is set up, then read out of the line store as one typed result per cycle while it stays free.
// Single result register: input is held off while a result waits unaccepted.
// Reset (synchronous, active low): parser idle, line empty, no result pending.
// Depends on kedlb_pkg, kedlb_ctrl and kedlb_dp.
module key_escape_decoder_line_buffer_core
    import kedlb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] key_byte
    input  logic                  s_axis_tuser,   // [0] cmd (1 = clear the line)
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] line_char, [14:8] line_length
    output logic [CMD_W-1:0]      m_axis_tuser,   // [3:0] command
    output logic                  m_axis_tlast    // last result of this transaction
);

    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;
    t_command          out_cmd;
    logic [CHAR_W-1:0] out_char;
    logic [LEN_W-1:0]  out_len;

    // parser + drain sequencer
    kedlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_clear (s_axis_tuser),
        .i_key_byte (s_axis_tdata),
        .i_status   (dp_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    // line store and result register
    kedlb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_key_byte  (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (dp_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_cmd   (out_cmd),
        .o_out_char  (out_char),
        .o_out_len   (out_len),
        .o_out_last  (m_axis_tlast)
    );

    // pack result fields, top bit padded to a whole byte
    assign m_axis_tdata = {1'b0, out_len, out_char};
    assign m_axis_tuser = out_cmd;

endmodule

FILE: dv/tb_key_escape_decoder_line_buffer_core.sv
// Self-checking testbench for key_escape_decoder_line_buffer_core.
// Drives keyboard bytes and line clears and checks each result against a
// behavioral decoder. Depends on kedlb_pkg and the RTL under src/.
module tb_key_escape_decoder_line_buffer_core;
    import kedlb_pkg::*;

    localparam int RANDOM_ITEMS = 345;
    localparam int DIR_ROWS     = 25;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 90;     // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int QUIET_FIRST  = 160;    // random items run with no idling
    localparam int QUIET_LAST   = 230;
    localparam int HOLD_AT      = 110;
    localparam int PAUSE_AT     = 260;

    // One input transaction; pin_* carries a hand-written expectation for
    // directed rows that give a single, obvious result.
    typedef struct {
        logic        clr;
        logic [7:0]  key;
        bit          pin;
        t_command    pin_cmd;
        logic [6:0]  pin_len;
    } t_key_item;

    typedef struct {
        t_command    command;
        logic [7:0]  ch;
        logic [6:0]  len;
        logic        is_last;
    } t_decoded;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;     // [7:0] key_byte
    logic                  s_axis_tuser = 1'b0;   // [0] cmd (1 = clear the line)
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // [7:0] line_char, [14:8] line_length
    logic [CMD_W-1:0]      m_axis_tuser;          // [3:0] command
    logic                  m_axis_tlast;

    t_key_item   bus_item;          // mirror of the item on the slave side
    t_key_item   stim_q[$];
    t_decoded    decoded_q[$];      // results predicted but not yet seen
    int          err_cnt = 0;
    int          stall_cnt = 0;
    logic        quiet = 1'b0;      // no idling on either side
    logic        hold_req = 1'b0;   // ask the receiver for a long hold-off

    // Behavioral copy of the decoder state
    t_parse_state        esc_state;
    logic [7:0]          line_chars [MAX_LINE_LEN];
    int                  line_len;

    always #6 i_clk = ~i_clk;

    key_escape_decoder_line_buffer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Directed opening: empty-line cases, the up, enter, move-left and move-right escape commands, quit inside a
    // sequence, swallowed and missing tilde, ESC that breaks a sequence,
    // high byte, a short line sent out, then a clear.
    t_key_item dir_tab [DIR_ROWS] = '{
        '{1'b0, KEY_CR,        1'b1, OP_TYPED,      7'd0},  // enter on empty line
        '{1'b0, KEY_DEL,       1'b1, OP_NONE,       7'd0},  // delete on empty line
        '{1'b0, KEY_ESC,       1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_BACKQUOTE, 1'b1, OP_QUIT,       7'd0},  // quit keeps the ESC state
        '{1'b0, KEY_BRACKET,   1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_A,         1'b1, OP_UP,         7'd0},
        '{1'b0, KEY_ESC,       1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_BRACKET,   1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_1,         1'b1, OP_ENTER,      7'd0},
        '{1'b0, KEY_TILDE,     1'b1, OP_NONE,       7'd0},  // swallowed
        '{1'b0, KEY_ESC,       1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_BRACKET,   1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_2,         1'b1, OP_MOVE_LEFT,  7'd0},
        '{1'b0, 8'h7a,         1'b1, OP_NONE,       7'd1},  // 'z' in place of tilde
        '{1'b0, KEY_ESC,       1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_BRACKET,   1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_5,         1'b1, OP_MOVE_RIGHT, 7'd1},
        '{1'b0, KEY_ESC,       1'b1, OP_NONE,       7'd1},  // dropped, no new sequence
        '{1'b0, KEY_ESC,       1'b0, OP_NONE,       7'd0},
        '{1'b0, KEY_ESC,       1'b1, OP_NONE,       7'd1},  // broken sequence
        '{1'b0, KEY_BRACKET,   1'b1, OP_NONE,       7'd1},
        '{1'b0, 8'hff,         1'b1, OP_NONE,       7'd1},  // high byte dropped
        '{1'b0, 8'h30,         1'b1, OP_NONE,       7'd2},
        '{1'b0, KEY_LF,        1'b0, OP_NONE,       7'd0},  // sends "z0"
        '{1'b1, 8'hff,         1'b1, OP_NONE,       7'd0}   // clear
    };

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------
    function automatic void post_result(t_command c, logic [7:0] ch, logic is_last);
        t_decoded r;
        r.command = c;
        r.ch      = ch;
        r.len     = 7'(line_len);
        r.is_last = is_last;
        decoded_q.push_back(r);
    endfunction

    // Typing and erase edit the line; returns 1 for a newline.
    function automatic bit edit_or_newline(logic [7:0] b);
        bit glyph;
        glyph = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
                (b >= "0" && b <= "9") || b == " ";
        if (b == KEY_BS || b == KEY_DEL) begin
            if (line_len > 0) line_len--;
        end else if (glyph && line_len < MAX_LINE_LEN) begin
            line_chars[line_len] = b;
            line_len++;
        end
        return b == KEY_CR || b == KEY_LF;
    endfunction

    function automatic void decode_keystroke(logic clr, logic [7:0] b);
        t_command c;
        bit       send_line;
        c = OP_NONE;
        send_line = 1'b0;
        if (clr) begin
            line_len = 0;
            post_result(OP_NONE, 8'd0, 1'b1);
            return;
        end
        if (b == KEY_BACKQUOTE) begin
            post_result(OP_QUIT, 8'd0, 1'b1);
            return;
        end
        case (esc_state)
            PS_IDLE: begin
                if (b == KEY_ESC) esc_state = PS_ESC;
                else send_line = edit_or_newline(b);
            end
            PS_ESC: begin
                if (b == KEY_BRACKET) begin
                    esc_state = PS_CSI;
                end else begin
                    esc_state = PS_IDLE;
                    send_line = edit_or_newline(b);
                end
            end
            PS_CSI: begin
                esc_state = PS_IDLE;
                case (b)
                    KEY_A: c = OP_UP;
                    KEY_B: c = OP_DOWN;
                    KEY_C: c = OP_RIGHT;
                    KEY_D: c = OP_LEFT;
                    KEY_1: begin c = OP_ENTER;      esc_state = PS_TILDE; end
                    KEY_2: begin c = OP_MOVE_LEFT;  esc_state = PS_TILDE; end
                    KEY_5: begin c = OP_MOVE_RIGHT; esc_state = PS_TILDE; end
                    default: send_line = edit_or_newline(b);
                endcase
            end
            default: begin
                esc_state = PS_IDLE;
                if (b != KEY_TILDE) send_line = edit_or_newline(b);
            end
        endcase
        if (!send_line) begin
            post_result(c, 8'd0, 1'b1);
        end else if (line_len == 0) begin
            post_result(OP_TYPED, 8'd0, 1'b1);
        end else begin
            for (int k = 0; k < line_len; k++)
                post_result(OP_TYPED, line_chars[k], k == line_len - 1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Random stimulus
    // ---------------------------------------------------------------
    function automatic void queue_key(logic clr, logic [7:0] b);
        t_key_item it;
        it.clr     = clr;
        it.key     = b;
        it.pin     = 1'b0;
        it.pin_cmd = OP_NONE;
        it.pin_len = 7'd0;
        stim_q.push_back(it);
    endfunction

    function automatic logic [7:0] rand_glyph();
        case ($urandom_range(3))
            0: return 8'("A" + $urandom_range(25));
            1: return 8'("a" + $urandom_range(25));
            2: return 8'("0" + $urandom_range(9));
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] rand_csi_final();
        case ($urandom_range(6))
            0: return KEY_A;
            1: return KEY_B;
            2: return KEY_C;
            3: return KEY_D;
            4: return KEY_1;
            5: return KEY_2;
            default: return KEY_5;
        endcase
    endfunction

    function automatic void build_random_stim();
        int          r;
        logic [7:0]  fin;
        while (stim_q.size() < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 30) begin
                queue_key(1'b0, rand_glyph());
            end else if (r < 36) begin
                queue_key(1'b0, $urandom_range(1) ? KEY_BS : KEY_DEL);
            end else if (r < 43) begin
                queue_key(1'b0, $urandom_range(1) ? KEY_CR : KEY_LF);
            end else if (r < 63) begin
                // well-formed sequence, tilde mostly present after 1/2/5
                fin = rand_csi_final();
                queue_key(1'b0, KEY_ESC);
                queue_key(1'b0, KEY_BRACKET);
                queue_key(1'b0, fin);
                if (fin == KEY_1 || fin == KEY_2 || fin == KEY_5)
                    queue_key(1'b0, ($urandom_range(3) != 0) ? KEY_TILDE
                                                             : 8'($urandom_range(255)));
            end else if (r < 67) begin
                // quit alone or in the middle of a sequence
                if ($urandom_range(1)) begin
                    queue_key(1'b0, KEY_ESC);
                    if ($urandom_range(1)) queue_key(1'b0, KEY_BRACKET);
                end
                queue_key(1'b0, KEY_BACKQUOTE);
            end else if (r < 70) begin
                queue_key(1'b1, 8'($urandom_range(255)));
            end else if (r < 78) begin
                // broken sequence
                queue_key(1'b0, KEY_ESC);
                if ($urandom_range(1)) queue_key(1'b0, KEY_BRACKET);
                queue_key(1'b0, $urandom_range(1) ? rand_glyph() : 8'($urandom_range(255)));
            end else if (r < 86) begin
                queue_key(1'b0, 8'($urandom_range(255)));
            end else if (r < 90) begin
                // burst long enough to hit the full-line case
                repeat ($urandom_range(24, 15)) queue_key(1'b0, rand_glyph());
            end else if (r < 95) begin
                queue_key(1'b0, 8'($urandom_range(255, 128)));
            end else begin
                queue_key(1'b0, KEY_ESC);
                queue_key(1'b0, KEY_ESC);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Slave-side driver
    // ---------------------------------------------------------------
    task automatic send_item(t_key_item it);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.key;
        s_axis_tuser  <= it.clr;
        bus_item      <= it;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Master-side receiver: random backpressure plus one long hold-off
    // ---------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req      <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check results, predict on accepted inputs, watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_decoded e;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (decoded_q.size() == 0) begin
                    $error("result with nothing expected: command %0d char %0d",
                           m_axis_tuser, m_axis_tdata[7:0]);
                    err_cnt++;
                end else begin
                    e = decoded_q.pop_front();
                    if (m_axis_tuser != e.command) begin
                        $error("command: expected %0d, got %0d", e.command, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tdata[7:0] != e.ch) begin
                        $error("line_char: expected %0d, got %0d", e.ch, m_axis_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[14:8] != e.len) begin
                        $error("line_length: expected %0d, got %0d",
                               e.len, m_axis_tdata[14:8]);
                        err_cnt++;
                    end
                    if (m_axis_tlast != e.is_last) begin
                        $error("last: expected %0d, got %0d", e.is_last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                decode_keystroke(s_axis_tuser, s_axis_tdata);
                // hand-written rows give one result: pin it to the typed value
                if (bus_item.pin) begin
                    e.command = bus_item.pin_cmd;
                    e.ch      = 8'd0;
                    e.len     = bus_item.pin_len;
                    e.is_last = 1'b1;
                    decoded_q[decoded_q.size() - 1] = e;
                end
            end
            stall_cnt = moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("** key_escape_decoder_line_buffer_core: FAILED **");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_key_item idle_item;
        idle_item = '{1'b0, 8'd0, 1'b0, OP_NONE, 7'd0};
        bus_item  = idle_item;
        esc_state = PS_IDLE;
        line_len  = 0;
        foreach (line_chars[i]) line_chars[i] = 8'd0;
        build_random_stim();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_item(dir_tab[i]);

        foreach (stim_q[i]) begin
            if (i == HOLD_AT)     hold_req <= 1'b1;   // block fills and stalls input
            if (i == PAUSE_AT)    wait_drained();
            if (i == QUIET_FIRST) quiet <= 1'b1;
            if (i == QUIET_LAST)  quiet <= 1'b0;
            send_item(stim_q[i]);
        end

        wait_drained();
        // idle on to catch stray results
        repeat (MAX_LINE_LEN + 4) @(posedge i_clk);
        if (err_cnt == 0)
            $display("** key_escape_decoder_line_buffer_core: PASSED **");
        else
            $display("** key_escape_decoder_line_buffer_core: FAILED **");
        $finish;
    end

endmodule
